/* rtl/assert_macros.svh */
// Assertion macros for the quadrature knob decoder RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/qkd_pkg.sv */
// Shared types, register codes and transition tables for the quadrature knob decoder.
// No dependencies; imported by qkd_step and quadrature_knob_decoder_unit.
package qkd_pkg;

  // Detent mode register
  localparam int unsigned ModeWidth = 3;
  localparam logic [ModeWidth-1:0] DETENT_ALL   = 3'd0;
  localparam logic [ModeWidth-1:0] DETENT_HALF  = 3'd1;
  localparam logic [ModeWidth-1:0] DETENT_FULL  = 3'd2;
  localparam logic [ModeWidth-1:0] DETENT_ALT   = 3'd3;
  localparam logic [ModeWidth-1:0] DETENT_QUART = 3'd4;
  localparam logic [ModeWidth-1:0] DETENT_RESET = DETENT_ALL;

  // One input item
  typedef struct packed {
    logic               pin_a_level;
    logic               pin_b_level;
    logic               button_level;
    logic               load_position;
    logic signed [31:0] new_position;
    logic               take_press;
    logic               clear_press;
  } qkd_in_t;

  // One result item
  typedef struct packed {
    logic signed [31:0] position;
    logic [15:0]        press_total;
    logic               press_seen;
  } qkd_out_t;

  // Decoder state carried from item to item
  typedef struct packed {
    logic [1:0]         last_pins;
    logic signed [31:0] position;
    logic               last_button;
    logic [15:0]        press_count;
    logic [15:0]        reported_count;
  } qkd_state_t;

  // Transition codes {old_a, old_b, new_a, new_b} that step the position up
  function automatic logic [15:0] up_mask(input logic [ModeWidth-1:0] mode);
    logic [15:0] mask;
    unique case (mode)
      DETENT_ALL:   mask = 16'h2814;
      DETENT_HALF:  mask = 16'h2800;
      DETENT_FULL:  mask = 16'h2000;
      DETENT_ALT:   mask = 16'h0800;
      DETENT_QUART: mask = 16'h0804;
      default:      mask = 16'h0000;
    endcase
    return mask;
  endfunction

  // Transition codes that step the position down
  function automatic logic [15:0] down_mask(input logic [ModeWidth-1:0] mode);
    logic [15:0] mask;
    unique case (mode)
      DETENT_ALL:   mask = 16'h4182;
      DETENT_HALF:  mask = 16'h4080;
      DETENT_FULL:  mask = 16'h4000;
      DETENT_ALT:   mask = 16'h0080;
      DETENT_QUART: mask = 16'h0082;
      default:      mask = 16'h0000;
    endcase
    return mask;
  endfunction

endpackage

/* rtl/qkd_step.sv */
// Next-state and result logic for one decoder item.
// Depends on qkd_pkg for the item, result and state types and the code tables.
module qkd_step (
  input  logic [qkd_pkg::ModeWidth-1:0] mode_i,
  input  qkd_pkg::qkd_state_t           state_i,
  input  qkd_pkg::qkd_in_t              item_i,
  output qkd_pkg::qkd_state_t           state_o,
  output qkd_pkg::qkd_out_t             result_o
);
  import qkd_pkg::*;

  logic [1:0]         pins;
  logic [3:0]         code;
  logic [15:0]        up_bits;
  logic [15:0]        down_bits;
  logic               step_up;
  logic               step_down;
  logic signed [31:0] pos_counted;
  logic signed [31:0] pos_next;
  logic               btn_fall;
  logic [15:0]        cnt_bumped;
  logic               seen;
  logic [15:0]        rep_taken;

  // Form the transition code and look up its direction
  assign pins      = {item_i.pin_a_level, item_i.pin_b_level};
  assign code      = {state_i.last_pins, pins};
  assign up_bits   = up_mask(mode_i);
  assign down_bits = down_mask(mode_i);
  assign step_up   = up_bits[code];
  assign step_down = down_bits[code];

  // Count the step, then apply the load
  always_comb begin
    if (step_up) begin
      pos_counted = state_i.position + 32'sd1;
    end else if (step_down) begin
      pos_counted = state_i.position - 32'sd1;
    end else begin
      pos_counted = state_i.position;
    end
  end
  assign pos_next = item_i.load_position ? item_i.new_position : pos_counted;

  // Bump the press count on a falling button edge
  assign btn_fall   = state_i.last_button & ~item_i.button_level;
  assign cnt_bumped = btn_fall ? state_i.press_count + 16'd1 : state_i.press_count;

  // Take: report a change since the last take or clear
  assign seen      = item_i.take_press && (cnt_bumped != state_i.reported_count);
  assign rep_taken = item_i.take_press ? cnt_bumped : state_i.reported_count;

  // Assemble next state; clear drops both counts after reporting
  always_comb begin
    state_o.last_pins      = pins;
    state_o.position       = pos_next;
    state_o.last_button    = item_i.button_level;
    state_o.press_count    = item_i.clear_press ? 16'd0 : cnt_bumped;
    state_o.reported_count = item_i.clear_press ? 16'd0 : rep_taken;
  end

  assign result_o.position    = pos_next;
  assign result_o.press_total = cnt_bumped;
  assign result_o.press_seen  = seen;

endmodule

/* rtl/quadrature_knob_decoder_unit.sv */
// Quadrature knob decoder top level: input register, step logic, result register.
// Depends on qkd_pkg, qkd_step and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one sample of pins A/B,
//   the button and the load/take/clear strobes per transfer.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one result per item
//   carrying the position, the press total and the press indication.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_detent_mode_i): writes the
//   detent mode; always ready. Write it only while no item is in flight.
// Timing:
//   An accepted item sits in the input register, is decoded, and is written to
//   the result register as it advances; from there it can be taken. One item
//   per cycle is sustained while the output is not stalled; the state update
//   (position add, press counter) is combinational between the registers.
// Reset:
//   Both registers empty, position and counts zero, last pins 00, button
//   released, detent mode 0 (every edge counts).
// Stall:
//   A stalled result holds in the result register; the input register still
//   takes one more item, after which in_stall_o follows out_stall_i.
`include "assert_macros.svh"

module quadrature_knob_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [qkd_pkg::ModeWidth-1:0] cfg_detent_mode_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  qkd_pkg::qkd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output qkd_pkg::qkd_out_t             out_data_o
);
  import qkd_pkg::*;

  logic [ModeWidth-1:0] mode_q;
  logic                 in_valid_q;
  qkd_in_t              in_q;
  logic                 out_valid_q;
  qkd_out_t             out_q;
  qkd_state_t           state_q;
  qkd_state_t           state_d;
  qkd_out_t             result_d;
  logic                 out_free;
  logic                 advance;
  logic                 in_xfer;

  // Handshake control
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign advance     = in_valid_q & out_free;
  assign in_stall_o  = in_valid_q & ~out_free;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Hold the detent mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= DETENT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_detent_mode_i;
    end
  end

  // Input register: load on transfer, drop when the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  qkd_step u_step (
    .mode_i   (mode_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Advance decoder state with each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.last_pins      <= 2'b00;
      state_q.position       <= 32'sd0;
      state_q.last_button    <= 1'b1;
      state_q.press_count    <= 16'd0;
      state_q.reported_count <= 16'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `ASSERT_RST(a_advance_fills_out, clk_i, rst_ni, advance |=> out_valid_q, "item lost between registers")
  `ASSERT_RST(a_seen_needs_take, clk_i, rst_ni, (advance && !in_q.take_press) |=> !out_q.press_seen, "press_seen without take")
  `ASSERT_RST(a_pos_step, clk_i, rst_ni, (advance && !in_q.load_position) |=> ((state_q.position - $past(state_q.position)) == 32'sd0 || (state_q.position - $past(state_q.position)) == 32'sd1 || (state_q.position - $past(state_q.position)) == -32'sd1), "position moved more than one step")
  `ASSERT_ALWAYS(a_idle_no_stall, clk_i, !in_valid_q |-> !in_stall_o, "stall with empty input register")

endmodule

/* tb/sv/quadrature_knob_decoder_unit_tb.sv */
// Self-checking testbench for quadrature_knob_decoder_unit: directed table, random
// quadrature walks per detent mode, full-rate press burst. Depends on qkd_pkg.
`timescale 1ns / 1ps

module quadrature_knob_decoder_unit_tb;
  import qkd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASE_ITEMS   = 180;
  localparam int unsigned BURST_PRESSES = 64;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 17;

  // Detent settings outside the decoded range: they count nothing
  localparam logic [ModeWidth-1:0] DETENT_NONE_A = 3'd5;
  localparam logic [ModeWidth-1:0] DETENT_NONE_B = 3'd6;
  localparam logic [ModeWidth-1:0] DETENT_NONE_C = 3'd7;

  // Transition codes {old_a, old_b, new_a, new_b}
  localparam logic [3:0] UP_11_01 = 4'b1101;
  localparam logic [3:0] UP_01_00 = 4'b0100;
  localparam logic [3:0] UP_00_10 = 4'b0010;
  localparam logic [3:0] UP_10_11 = 4'b1011;
  localparam logic [3:0] DN_11_10 = 4'b1110;
  localparam logic [3:0] DN_01_11 = 4'b0111;
  localparam logic [3:0] DN_00_01 = 4'b0001;
  localparam logic [3:0] DN_10_00 = 4'b1000;

  typedef struct {
    qkd_in_t  item;
    bit       typed;
    qkd_out_t result;
  } knob_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [ModeWidth-1:0] cfg_detent_mode_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  qkd_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  qkd_out_t             out_data_o;

  // Shadow state of the decoder
  logic [ModeWidth-1:0] detent_mode;
  logic [1:0]           knob_pins;
  logic signed [31:0]   knob_pos;
  logic                 button_prev;
  logic [15:0]          press_count;
  logic [15:0]          press_reported;

  qkd_out_t             expected_results[$];
  qkd_out_t             want;
  int unsigned          mismatches;
  int unsigned          results_checked;
  int unsigned          items_sent;
  int unsigned          modes_written;
  int unsigned          cycles;
  int unsigned          hold_left;
  bit                   hold_done;
  bit                   quiet;

  quadrature_knob_decoder_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_detent_mode_i (cfg_detent_mode_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_data_i         (in_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_data_o        (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Direction of one transition under a detent setting: +1, -1 or 0
  function automatic int detent_step(input logic [ModeWidth-1:0] mode, input logic [3:0] code);
    int dir;
    dir = 0;
    case (mode)
      DETENT_ALL: begin
        case (code)
          UP_11_01, UP_01_00, UP_00_10, UP_10_11: dir = 1;
          DN_11_10, DN_01_11, DN_00_01, DN_10_00: dir = -1;
          default: dir = 0;
        endcase
      end
      DETENT_HALF: begin
        case (code)
          UP_11_01, UP_10_11: dir = 1;
          DN_11_10, DN_01_11: dir = -1;
          default: dir = 0;
        endcase
      end
      DETENT_FULL: begin
        if (code == UP_11_01) dir = 1;
        else if (code == DN_11_10) dir = -1;
      end
      DETENT_ALT: begin
        if (code == UP_10_11) dir = 1;
        else if (code == DN_01_11) dir = -1;
      end
      DETENT_QUART: begin
        case (code)
          UP_00_10, UP_10_11: dir = 1;
          DN_01_11, DN_00_01: dir = -1;
          default: dir = 0;
        endcase
      end
      default: dir = 0;
    endcase
    return dir;
  endfunction

  // Advance the shadow state by one sample and return the result it yields
  function automatic qkd_out_t predict_knob(input qkd_in_t item);
    qkd_out_t   res;
    logic [1:0] pins;
    pins = {item.pin_a_level, item.pin_b_level};
    knob_pos = knob_pos + detent_step(detent_mode, {knob_pins, pins});
    knob_pins = pins;
    if (item.load_position) knob_pos = item.new_position;
    if (button_prev && !item.button_level) press_count = press_count + 16'd1;
    button_prev = item.button_level;
    res.press_seen = 1'b0;
    if (item.take_press) begin
      res.press_seen = (press_count != press_reported);
      press_reported = press_count;
    end
    res.press_total = press_count;
    if (item.clear_press) begin
      press_count = '0;
      press_reported = '0;
    end
    res.position = knob_pos;
    return res;
  endfunction

  function automatic knob_row_t knob_row(input int a, b, btn, load, input logic [31:0] newpos,
                                         input int take, clear, typed,
                                         input logic [31:0] pos, input logic [15:0] total,
                                         input int seen);
    knob_row_t r;
    r.item.pin_a_level   = a[0];
    r.item.pin_b_level   = b[0];
    r.item.button_level  = btn[0];
    r.item.load_position = load[0];
    r.item.new_position  = newpos;
    r.item.take_press    = take[0];
    r.item.clear_press   = clear[0];
    r.typed              = typed[0];
    r.result.position    = pos;
    r.result.press_total = total;
    r.result.press_seen  = seen[0];
    return r;
  endfunction

  // Offer one sample, with random idle cycles ahead of it unless quiet, and record its result
  task automatic send_item(input qkd_in_t item, input bit typed, input qkd_out_t typed_res);
    qkd_out_t predicted;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_knob(item);
    items_sent++;
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_detent(input logic [ModeWidth-1:0] mode);
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_detent_mode_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    detent_mode = mode;
    modes_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val, got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h got %h", results_checked, name, exp_val, got_val);
    end
  endtask

  // Receiver stall: one long hold-off, quiet stretches, otherwise random
  initial out_stall_i = 1'b0;
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_checked >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each transfer on the result channel with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        want = expected_results.pop_front();
        check_field("position", want.position, out_data_o.position);
        check_field("press_total", {16'd0, want.press_total}, {16'd0, out_data_o.press_total});
        check_field("press_seen", {31'd0, want.press_seen}, {31'd0, out_data_o.press_seen});
      end
      results_checked++;
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    knob_row_t            rows[$];
    logic [ModeWidth-1:0] phase_modes[$];
    logic [1:0]           gray_order[4];
    logic [1:0]           gray_idx;
    logic [1:0]           pins;
    bit                   spin_up;
    logic                 btn;
    qkd_in_t              item;
    qkd_out_t             none;
    int unsigned          pick;

    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_detent_mode_i = DETENT_RESET;
    in_valid_i        = 1'b0;
    in_data_i         = '0;
    quiet             = 1'b0;
    hold_left         = 0;
    hold_done         = 1'b0;
    mismatches        = 0;
    results_checked   = 0;
    items_sent        = 0;
    modes_written     = 0;
    cycles            = 0;
    none              = '0;
    detent_mode       = DETENT_RESET;
    knob_pins         = 2'b00;
    knob_pos          = '0;
    button_prev       = 1'b1;
    press_count       = '0;
    press_reported    = '0;
    gray_order        = '{2'b00, 2'b10, 2'b11, 2'b01};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: reset state, position wrap both ways, every transition,
    // button edges with take and clear alone and together, load after counting
    rows.push_back(knob_row(0, 0, 1, 0, 32'h0, 0, 0, 1, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 0, 1, 0, 32'h0, 1, 0, 1, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 0, 1, 1, 32'h7FFFFFFF, 0, 0, 1, 32'h7FFFFFFF, 16'd0, 0));
    rows.push_back(knob_row(1, 0, 1, 0, 32'hFFFFFFFF, 0, 0, 1, 32'h80000000, 16'd0, 0));
    rows.push_back(knob_row(1, 1, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(1, 0, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 0, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 0, 1, 1, 32'h80000000, 0, 0, 1, 32'h80000000, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 1, 0, 32'h0, 0, 0, 1, 32'h7FFFFFFF, 16'd0, 0));
    rows.push_back(knob_row(1, 1, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 0, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(1, 1, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 0, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(1, 0, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 1, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 0, 0, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 0, 0, 32'h0, 1, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 1, 0, 32'h0, 1, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 0, 0, 32'h0, 1, 1, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 1, 0, 32'h0, 1, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(0, 1, 0, 0, 32'h0, 0, 1, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(1, 1, 1, 1, 32'h0, 0, 0, 0, 32'h0, 16'd0, 0));
    rows.push_back(knob_row(1, 1, 1, 1, 32'h5555AAAA, 0, 0, 0, 32'h0, 16'd0, 0));

    write_detent(DETENT_ALL);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);
    drain_results();

    // Random phases: quadrature walks with noise under every detent setting
    phase_modes = '{DETENT_ALL, DETENT_HALF, DETENT_FULL, DETENT_ALT, DETENT_QUART,
                    DETENT_NONE_C, DETENT_NONE_A, DETENT_NONE_B, DETENT_ALL};
    gray_idx = 2'd0;
    spin_up  = 1'b1;
    btn      = button_prev;
    foreach (phase_modes[p]) begin
      write_detent(phase_modes[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) gray_idx = spin_up ? gray_idx + 2'd1 : gray_idx - 2'd1;
        else if (pick < 80) gray_idx = gray_idx;
        else if (pick < 90) gray_idx = gray_idx + 2'd2;
        else gray_idx = 2'($urandom_range(3));
        if ($urandom_range(99) < 8) spin_up = !spin_up;
        if ($urandom_range(99) < 25) btn = !btn;
        pins = gray_order[gray_idx];
        item.pin_a_level   = pins[1];
        item.pin_b_level   = pins[0];
        item.button_level  = btn;
        item.load_position = ($urandom_range(99) < 4);
        case ($urandom_range(3))
          0: item.new_position = 32'h7FFFFFFF;
          1: item.new_position = 32'h80000000;
          default: item.new_position = $urandom;
        endcase
        item.take_press  = ($urandom_range(99) < 20);
        item.clear_press = ($urandom_range(99) < 6);
        send_item(item, 1'b0, none);
      end
      drain_results();

      // Full-rate press burst with no idling on either side
      if (phase_modes[p] == DETENT_QUART) begin
        quiet = 1'b1;
        item = '0;
        item.pin_a_level  = pins[1];
        item.pin_b_level  = pins[0];
        item.button_level = 1'b1;
        item.clear_press  = 1'b1;
        send_item(item, 1'b0, none);
        item.clear_press = 1'b0;
        for (int n = 0; n < BURST_PRESSES; n++) begin
          item.button_level = 1'b0;
          item.take_press   = (n % 16 == 0);
          send_item(item, 1'b0, none);
          item.button_level = 1'b1;
          item.take_press   = 1'b0;
          send_item(item, 1'b0, none);
        end
        btn = 1'b1;
        drain_results();
        quiet = 1'b0;
      end
    end

    if (expected_results.size() != 0) mismatches += expected_results.size();
    $display("Sent %0d samples under %0d detent writes, checked %0d results, %0d mismatches",
             items_sent, modes_written, results_checked, mismatches);
    $display("Included a %0d-cycle output hold and a full-rate press burst", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/qkd_pkg.sv
rtl/qkd_step.sv
rtl/quadrature_knob_decoder_unit.sv
tb/sv/quadrature_knob_decoder_unit_tb.sv
